>>> hw/rtl/pidpd_pkg.sv
// Shared constants, register codes and types for the position PID drive core.
// Used by every module under hw/rtl; depends on nothing else.
package pidpd_pkg;

   // Field widths and fixed-point format
   localparam int POSITION_WIDTH     = 24;
   localparam int GAIN_FRACTION_BITS = 16;
   localparam int GAIN_W             = 24;
   localparam int ZONE_W             = 23;
   localparam int LIMIT_W            = 7;
   localparam int POWER_W            = LIMIT_W + 1;
   localparam int SUM_W              = 32;

   // Derived datapath widths
   localparam int ERR_W   = POSITION_WIDTH + 1;
   localparam int DERIV_W = POSITION_WIDTH + 2;
   localparam int ACCUM_W = SUM_W - 1;  // integral never goes negative
   localparam int CMP_W   = ((ERR_W > ZONE_W) ? ERR_W : ZONE_W) + 1;
   localparam int P_W     = GAIN_W + 1 + ERR_W;
   localparam int I_W     = GAIN_W + 1 + SUM_W;
   localparam int D_W     = GAIN_W + 1 + DERIV_W;
   localparam int PD_W    = (P_W > D_W) ? P_W : D_W;
   localparam int PROD_W  = (PD_W > I_W) ? PD_W : I_W;
   localparam int ACC_W   = PROD_W + 2;

   // Port widths
   localparam int REQ_DATA_W  = ((POSITION_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((POWER_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = (POSITION_WIDTH > GAIN_W) ? POSITION_WIDTH : GAIN_W;

   // Register reset values
   localparam logic [GAIN_W-1:0]  GAIN_P_RESET = GAIN_W'(32768);
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET = GAIN_W'(66);
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET = GAIN_W'(1966);
   localparam logic [ZONE_W-1:0]  ZONE_RESET   = ZONE_W'(3000);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(127);

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET  = 3'd0,
      CSR_REVERSE = 3'd1,
      CSR_GAIN_P  = 3'd2,
      CSR_GAIN_I  = 3'd3,
      CSR_GAIN_D  = 3'd4,
      CSR_ZONE    = 3'd5,
      CSR_LIMIT   = 3'd6
   } pidpd_csr_index_type;

   typedef struct packed {
      logic signed [POSITION_WIDTH-1:0] target;
      logic                             reverse;
      logic [GAIN_W-1:0]                gain_p;
      logic [GAIN_W-1:0]                gain_i;
      logic [GAIN_W-1:0]                gain_d;
      logic [ZONE_W-1:0]                zone;
      logic [LIMIT_W-1:0]               limit;
   } pidpd_cfg_type;

endpackage

>>> hw/rtl/pidpd_error_stage.sv
// Error stage: forms the position error, updates the integral and derivative state.
// Depends on pidpd_pkg.
module pidpd_error_stage (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load,
   input  logic                                       step,
   input  logic signed [pidpd_pkg::POSITION_WIDTH-1:0] position,
   input  logic                                       restart,
   input  pidpd_pkg::pidpd_cfg_type                   cfg,
   output logic signed [pidpd_pkg::ERR_W-1:0]         err_ff,
   output logic [pidpd_pkg::ACCUM_W-1:0]              accum_ff,
   output logic signed [pidpd_pkg::DERIV_W-1:0]       deriv_ff,
   output logic                                       done_ff
);
   import pidpd_pkg::*;

   logic [ACCUM_W-1:0]        error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]   last_error_ff;
   logic signed [ERR_W-1:0]   err;
   logic signed [CMP_W-1:0]   err_cmp;
   logic signed [CMP_W-1:0]   zone_cmp;
   logic                      err_pos;
   logic                      in_zone;
   logic [ACCUM_W-1:0]        sum_base;
   logic [SUM_W-1:0]          sum_add;
   logic signed [ERR_W-1:0]   last_base;
   logic signed [DERIV_W-1:0] deriv;

   // Error and integral-zone test
   assign err      = ERR_W'(cfg.target) - ERR_W'(position);
   assign err_cmp  = CMP_W'(err);
   assign zone_cmp = $signed(CMP_W'(cfg.zone));
   assign err_pos  = !err[ERR_W-1] && (err != '0);
   assign in_zone  = err_pos && (err_cmp <= zone_cmp);

   // Restart clears the carried state before this word is used
   assign sum_base  = restart ? '0 : error_sum_ff;
   assign last_base = restart ? '0 : last_error_ff;

   // Saturating integral; err is known to fit the zone width here
   assign sum_add = {1'b0, sum_base} + SUM_W'(err_cmp[ZONE_W-1:0]);
   always_comb begin
      if (!in_zone) begin
         error_sum_in = '0;
      end else if (sum_add[SUM_W-1]) begin
         error_sum_in = '1;
      end else begin
         error_sum_in = sum_add[ACCUM_W-1:0];
      end
   end

   assign deriv = DERIV_W'(err) - DERIV_W'(last_base);

   // Carried state
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (step) begin
         error_sum_ff  <= error_sum_in;
         last_error_ff <= err;
      end
   end

   // Stage output
   always_ff @(posedge clock) begin
      if (load) begin
         err_ff   <= err;
         accum_ff <= error_sum_in;
         deriv_ff <= deriv;
         done_ff  <= !err_pos;
      end
   end

endmodule

>>> hw/rtl/pidpd_mult_stage.sv
// Product stage: the three gain multiplications, each into its own register.
// Depends on pidpd_pkg.
module pidpd_mult_stage (
   input  logic                                 clock,
   input  logic                                 load,
   input  pidpd_pkg::pidpd_cfg_type             cfg,
   input  logic signed [pidpd_pkg::ERR_W-1:0]   err,
   input  logic [pidpd_pkg::ACCUM_W-1:0]        accum,
   input  logic signed [pidpd_pkg::DERIV_W-1:0] deriv,
   output logic signed [pidpd_pkg::P_W-1:0]     p_prod_ff,
   output logic signed [pidpd_pkg::I_W-1:0]     i_prod_ff,
   output logic signed [pidpd_pkg::D_W-1:0]     d_prod_ff
);
   import pidpd_pkg::*;

   logic signed [P_W-1:0] p_prod_in;
   logic signed [I_W-1:0] i_prod_in;
   logic signed [D_W-1:0] d_prod_in;

   // Gains are unsigned: a zero bit on top makes them signed operands
   assign p_prod_in = $signed({1'b0, cfg.gain_p}) * err;
   assign i_prod_in = $signed({1'b0, cfg.gain_i}) * $signed({1'b0, accum});
   assign d_prod_in = $signed({1'b0, cfg.gain_d}) * deriv;

   always_ff @(posedge clock) begin
      if (load) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
   end

endmodule

>>> hw/rtl/pidpd_output_stage.sv
// Output stages: sums the products, scales toward zero, applies direction and clamp.
// Depends on pidpd_pkg.
module pidpd_output_stage (
   input  logic                                 clock,
   input  logic                                 load,
   input  pidpd_pkg::pidpd_cfg_type             cfg,
   input  logic signed [pidpd_pkg::P_W-1:0]     p_prod,
   input  logic signed [pidpd_pkg::I_W-1:0]     i_prod,
   input  logic signed [pidpd_pkg::D_W-1:0]     d_prod,
   output logic signed [pidpd_pkg::POWER_W-1:0] power_ff
);
   import pidpd_pkg::*;

   localparam int SHIFT_W = ACC_W - GAIN_FRACTION_BITS;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    neg;
   logic [ACC_W-1:0]        mag;
   logic [SHIFT_W-1:0]      mag_int;
   logic                    over;
   logic [LIMIT_W-1:0]      mag_clamp;
   logic signed [POWER_W-1:0] power_in;

   // Weighted sum
   assign acc_in = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff <= acc_in;
      end
   end

   // Truncate toward zero by shifting the magnitude
   assign neg     = acc_ff[ACC_W-1];
   assign mag     = neg ? (~acc_ff + 1'b1) : acc_ff;
   assign mag_int = mag[ACC_W-1:GAIN_FRACTION_BITS];

   // Clamp magnitude, then apply sign and direction
   assign over      = (|mag_int[SHIFT_W-1:LIMIT_W]) || (mag_int[LIMIT_W-1:0] > cfg.limit);
   assign mag_clamp = over ? cfg.limit : mag_int[LIMIT_W-1:0];
   assign power_in  = (neg ^ cfg.reverse) ? -$signed({1'b0, mag_clamp})
                                          : $signed({1'b0, mag_clamp});

   always_ff @(posedge clock) begin
      if (load) begin
         power_ff <= power_in;
      end
   end

endmodule

>>> hw/rtl/pid_position_drive_core.sv
// Position PID drive controller top level: register file, input register and pipeline.
// Depends on pidpd_pkg, pidpd_error_stage, pidpd_mult_stage and pidpd_output_stage.
//
// One encoder position word in, one drive word out. A word on req_ is taken whenever the
// pipeline moves; it moves as a whole and stalls only while a result waits on rsp_
// unaccepted. Each result passes the input, error, product, sum and power registers.
// One word per cycle is sustained, set by the error stage: its integral and previous error
// update as each word passes, so the next word sees them at once. The user must write
// registers on csr_ only while the core holds no word in flight; the core does not enforce it.
module pid_position_drive_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [pidpd_pkg::REQ_DATA_W-1:0]      req_tdata,  // [23:0] position
   input  logic                                  req_tuser,  // [0] restart
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pidpd_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [7:0] drive_power
   output logic                                  rsp_tuser,  // [0] done_res
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pidpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pidpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pidpd_pkg::*;

   pidpd_cfg_type cfg_ff;

   logic                              advance;
   logic [4:0]                        valid_ff;
   logic signed [POSITION_WIDTH-1:0]  position_ff;
   logic                              restart_ff;
   logic signed [ERR_W-1:0]           err;
   logic [ACCUM_W-1:0]                accum;
   logic signed [DERIV_W-1:0]         deriv;
   logic                              done_s1;
   logic                              done_s2_ff, done_s3_ff, done_s4_ff;
   logic signed [P_W-1:0]             p_prod;
   logic signed [I_W-1:0]             i_prod;
   logic signed [D_W-1:0]             d_prod;
   logic signed [POWER_W-1:0]         power;

   // Register file
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target  <= '0;
         cfg_ff.reverse <= 1'b0;
         cfg_ff.gain_p  <= GAIN_P_RESET;
         cfg_ff.gain_i  <= GAIN_I_RESET;
         cfg_ff.gain_d  <= GAIN_D_RESET;
         cfg_ff.zone    <= ZONE_RESET;
         cfg_ff.limit   <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (pidpd_csr_index_type'(csr_index))
            CSR_TARGET:  cfg_ff.target  <= $signed(csr_wdata[POSITION_WIDTH-1:0]);
            CSR_REVERSE: cfg_ff.reverse <= csr_wdata[0];
            CSR_GAIN_P:  cfg_ff.gain_p  <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:  cfg_ff.gain_i  <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:  cfg_ff.gain_d  <= csr_wdata[GAIN_W-1:0];
            CSR_ZONE:    cfg_ff.zone    <= csr_wdata[ZONE_W-1:0];
            CSR_LIMIT:   cfg_ff.limit   <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Whole pipeline moves unless a result is held on the output
   assign advance    = !valid_ff[4] || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], req_tvalid};
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (advance) begin
         position_ff <= $signed(req_tdata[POSITION_WIDTH-1:0]);
         restart_ff  <= req_tuser;
      end
   end

   pidpd_error_stage u_error (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .step     (advance && valid_ff[0]),
      .position (position_ff),
      .restart  (restart_ff),
      .cfg      (cfg_ff),
      .err_ff   (err),
      .accum_ff (accum),
      .deriv_ff (deriv),
      .done_ff  (done_s1)
   );

   pidpd_mult_stage u_mult (
      .clock     (clock),
      .load      (advance),
      .cfg       (cfg_ff),
      .err       (err),
      .accum     (accum),
      .deriv     (deriv),
      .p_prod_ff (p_prod),
      .i_prod_ff (i_prod),
      .d_prod_ff (d_prod)
   );

   pidpd_output_stage u_output (
      .clock    (clock),
      .load     (advance),
      .cfg      (cfg_ff),
      .p_prod   (p_prod),
      .i_prod   (i_prod),
      .d_prod   (d_prod),
      .power_ff (power)
   );

   // Done flag rides alongside the datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         done_s2_ff <= done_s1;
         done_s3_ff <= done_s2_ff;
         done_s4_ff <= done_s3_ff;
      end
   end

   assign rsp_tvalid = valid_ff[4];
   assign rsp_tdata  = RSP_DATA_W'($unsigned(power));
   assign rsp_tuser  = done_s4_ff;

endmodule
